### hw/rtl/rcpa_pkg.sv
// Package for the reference-counted page allocator.
// Holds operation and status codes, controller states and the control structs.
// Used by rcpa_ctrl, rcpa_datapath and refcounted_page_allocator.
package rcpa_pkg;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADDREF  = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Status codes returned with every result.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_POPPED_USED = 3'd2,
        ST_REL_UNUSED  = 3'd3,
        ST_ADD_UNUSED  = 3'd4,
        ST_RANGE       = 3'd5
    } status_code_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_TOP   = 2'd2,
        S_EVAL  = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // latch the item and read both memories
        logic take_top;    // resolve the stack top and read its count
        logic evaluate;    // apply the operation and load the result
        logic clear_step;  // zero one count entry of the sweep
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_alloc;    // item on the input is an allocate
        logic clear_last;  // sweep is at the final entry
    } dp_stat_t;

endpackage

### hw/rtl/rcpa_ctrl.sv
// Controller state machine of the reference-counted page allocator.
// Sequences clearing, item acceptance, stack-top lookup and evaluation.
// Depends on rcpa_pkg.
module rcpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cfg_we,
    input  rcpa_pkg::dp_stat_t  stat,
    output rcpa_pkg::ctrl_cmd_t cmd,
    output logic                busy,
    output logic                done
);

    rcpa_pkg::state_t state_reg;
    rcpa_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    // State and strobe registers; reset starts the count clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcpa_pkg::S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            rcpa_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = rcpa_pkg::S_IDLE;
                end
            end
            rcpa_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.op_alloc ? rcpa_pkg::S_TOP : rcpa_pkg::S_EVAL;
                end
            end
            rcpa_pkg::S_TOP:
            begin
                cmd.take_top = 1'b1;
                state_next   = rcpa_pkg::S_EVAL;
            end
            rcpa_pkg::S_EVAL:
            begin
                cmd.evaluate = 1'b1;
                done_next    = 1'b1;
                state_next   = rcpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rcpa_pkg::S_CLEAR;
            end
        endcase
        // A register write reinitialises everything and restarts the sweep.
        if (cfg_we)
        begin
            state_next     = rcpa_pkg::S_CLEAR;
            cmd.clear_step = 1'b0;
        end
    end

    assign done = done_reg;

endmodule

### hw/rtl/rcpa_datapath.sv
// Datapath of the reference-counted page allocator: free-page stack memory,
// count memory, stack pointer and result registers.
// Depends on rcpa_pkg; driven by rcpa_ctrl.
module rcpa_datapath #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          operation,
    input  logic [11:0]         page,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_wdata,
    input  rcpa_pkg::ctrl_cmd_t cmd,
    output rcpa_pkg::dp_stat_t  stat,
    output logic [11:0]         page_index,
    output logic [7:0]          ref_count,
    output logic [12:0]         free_pages,
    output logic                released,
    output logic [2:0]          status
);

    localparam int          AW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int          CAP       = (MAX_PAGES > 8191) ? 8191 : MAX_PAGES;
    localparam logic [12:0] CAP13     = 13'(CAP);
    localparam logic [12:0] RST_PAGES = (MAX_PAGES < 4096) ? 13'(MAX_PAGES) : 13'd4096;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAGES - 1);

    // Memories.
    logic [11:0] stack_mem [MAX_PAGES];
    logic [7:0]  cnt_mem   [MAX_PAGES];
    logic [11:0] stack_rd_reg;
    logic [7:0]  cnt_rd_reg;

    // Control state.
    logic [12:0]   pages_reg;
    logic [12:0]   pages_next;
    logic [12:0]   free_top_reg;
    logic [12:0]   free_top_next;
    logic [12:0]   fill_mark_reg;
    logic [12:0]   fill_mark_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // Item registers.
    rcpa_pkg::op_t op_reg;
    logic [11:0]   page_reg;

    // Result registers.
    logic [11:0]            page_index_reg;
    logic [7:0]             ref_count_reg;
    logic [12:0]            free_pages_reg;
    logic                   released_reg;
    rcpa_pkg::status_code_t status_reg;

    // Evaluation signals.
    logic [12:0]            top_addr;
    logic [11:0]            top_page;
    logic [12:0]            cfg_pages;
    logic [11:0]            res_idx;
    logic [7:0]             res_cnt;
    logic                   res_rel;
    rcpa_pkg::status_code_t res_status;
    logic [12:0]            ft_eval;
    logic [12:0]            mark_eval;
    logic                   cnt_wr;
    logic [7:0]             cnt_wdata;
    logic                   push;

    // Memory port selection.
    logic          cnt_we;
    logic [AW-1:0] cnt_waddr;
    logic [7:0]    cnt_wval;
    logic          cnt_re;
    logic [AW-1:0] cnt_raddr;

    assign stat.op_alloc   = (operation == rcpa_pkg::OP_ALLOC);
    assign stat.clear_last = (clr_addr_reg == LAST_ADDR);

    // Stack top position; entries below the fill mark still hold their own index.
    assign top_addr = free_top_reg - 13'd1;
    assign top_page = (top_addr < fill_mark_reg) ? top_addr[11:0] : stack_rd_reg;

    // Register write value limited to the managed range.
    always_comb
    begin
        if (cfg_wdata == 13'd0)
        begin
            cfg_pages = 13'd1;
        end
        else if (cfg_wdata > CAP13)
        begin
            cfg_pages = CAP13;
        end
        else
        begin
            cfg_pages = cfg_wdata;
        end
    end

    // Operation evaluation on the latched item and the count read back.
    always_comb
    begin
        res_idx    = page_reg;
        res_cnt    = 8'd0;
        res_rel    = 1'b0;
        res_status = rcpa_pkg::ST_OK;
        ft_eval    = free_top_reg;
        mark_eval  = fill_mark_reg;
        cnt_wr     = 1'b0;
        cnt_wdata  = 8'd0;
        push       = 1'b0;
        case (op_reg)
            rcpa_pkg::OP_ALLOC:
            begin
                if (free_top_reg == 13'd0)
                begin
                    res_idx    = 12'd0;
                    res_status = rcpa_pkg::ST_EMPTY;
                end
                else if (cnt_rd_reg != 8'd0)
                begin
                    res_status = rcpa_pkg::ST_POPPED_USED;
                    res_cnt    = cnt_rd_reg;
                end
                else
                begin
                    ft_eval   = top_addr;
                    if (top_addr < fill_mark_reg)
                    begin
                        mark_eval = top_addr;
                    end
                    cnt_wr    = 1'b1;
                    cnt_wdata = 8'd1;
                    res_cnt   = 8'd1;
                end
            end
            default:
            begin
                if ({1'b0, page_reg} >= pages_reg)
                begin
                    res_status = rcpa_pkg::ST_RANGE;
                end
                else
                begin
                    res_cnt = cnt_rd_reg;
                    case (op_reg)
                        rcpa_pkg::OP_RELEASE:
                        begin
                            if (cnt_rd_reg == 8'd0)
                            begin
                                res_status = rcpa_pkg::ST_REL_UNUSED;
                            end
                            else
                            begin
                                res_cnt   = cnt_rd_reg - 8'd1;
                                cnt_wr    = 1'b1;
                                cnt_wdata = cnt_rd_reg - 8'd1;
                                if (cnt_rd_reg == 8'd1)
                                begin
                                    push    = 1'b1;
                                    ft_eval = free_top_reg + 13'd1;
                                    res_rel = 1'b1;
                                end
                            end
                        end
                        rcpa_pkg::OP_ADDREF:
                        begin
                            if (cnt_rd_reg == 8'd0)
                            begin
                                res_status = rcpa_pkg::ST_ADD_UNUSED;
                            end
                            else if (cnt_rd_reg == 8'hFF)
                            begin
                                res_status = rcpa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                res_cnt   = cnt_rd_reg + 8'd1;
                                cnt_wr    = 1'b1;
                                cnt_wdata = cnt_rd_reg + 8'd1;
                            end
                        end
                        default:
                        begin
                            res_cnt = cnt_rd_reg;
                        end
                    endcase
                end
            end
        endcase
    end

    // Next values of the control registers.
    always_comb
    begin
        pages_next     = pages_reg;
        free_top_next  = free_top_reg;
        fill_mark_next = fill_mark_reg;
        clr_addr_next  = clr_addr_reg;
        if (cfg_we)
        begin
            pages_next     = cfg_pages;
            free_top_next  = cfg_pages;
            fill_mark_next = cfg_pages;
            clr_addr_next  = '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            if (cmd.evaluate)
            begin
                free_top_next  = ft_eval;
                fill_mark_next = mark_eval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg     <= RST_PAGES;
            free_top_reg  <= RST_PAGES;
            fill_mark_reg <= RST_PAGES;
            clr_addr_reg  <= '0;
        end
        else
        begin
            pages_reg     <= pages_next;
            free_top_reg  <= free_top_next;
            fill_mark_reg <= fill_mark_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    // Item registers; the page is replaced by the stack top on allocate.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= rcpa_pkg::op_t'(operation);
            page_reg <= page;
        end
        else if (cmd.take_top)
        begin
            page_reg <= top_page;
        end
    end

    // Free-page stack memory: read the top on accept, push on release.
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate && push)
        begin
            stack_mem[AW'(free_top_reg)] <= page_reg;
        end
        if (cmd.accept)
        begin
            stack_rd_reg <= stack_mem[AW'(top_addr)];
        end
    end

    // Count memory port selection: the sweep and evaluation never overlap.
    assign cnt_we    = cmd.clear_step || (cmd.evaluate && cnt_wr);
    assign cnt_waddr = cmd.clear_step ? clr_addr_reg : AW'(page_reg);
    assign cnt_wval  = cmd.clear_step ? 8'd0 : cnt_wdata;
    assign cnt_re    = cmd.accept || cmd.take_top;
    assign cnt_raddr = cmd.accept ? AW'(page) : AW'(top_page);

    // Count memory.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wval;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate)
        begin
            page_index_reg <= res_idx;
            ref_count_reg  <= res_cnt;
            free_pages_reg <= ft_eval;
            released_reg   <= res_rel;
            status_reg     <= res_status;
        end
    end

    assign page_index = page_index_reg;
    assign ref_count  = ref_count_reg;
    assign free_pages = free_pages_reg;
    assign released   = released_reg;
    assign status     = status_reg;

endmodule

### hw/rtl/refcounted_page_allocator.sv
// Top level of the reference-counted page allocator.
// Joins the controller rcpa_ctrl and the datapath rcpa_datapath; uses rcpa_pkg.
//
// Usage:
//   An item (operation, page) is taken at a rising edge where start is high
//   and busy is low. Exactly one result per item appears on page_index,
//   ref_count, free_pages, released and status for one cycle, marked by done.
//   The receiver cannot stall; each result must be captured while done is high.
//   Release, add reference and query read the page's count and evaluate;
//   allocate first reads the stack top and then that page's count. busy
//   falls in the cycle that done is shown, so a new item is taken only once
//   the last item's result is shown. Configuration: cfg_we with cfg_wdata
//   writes pages_in_use (0 taken as 1, values above MAX_PAGES taken as
//   MAX_PAGES) and reinitialises the stack and counts. After reset and after
//   each write the block sweeps all MAX_PAGES entries of the count memory to
//   zero, one entry a cycle, with busy high; the stack needs no sweep, as a
//   fill mark stands for its untouched entries.
module refcounted_page_allocator #(
    parameter int MAX_PAGES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [11:0] page,
    output logic        done,
    output logic [11:0] page_index,
    output logic [7:0]  ref_count,
    output logic [12:0] free_pages,
    output logic        released,
    output logic [2:0]  status,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata
);

    rcpa_pkg::ctrl_cmd_t cmd;
    rcpa_pkg::dp_stat_t  stat;

    // Sequencing.
    rcpa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Memories and arithmetic.
    rcpa_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation),
        .page       (page),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .page_index (page_index),
        .ref_count  (ref_count),
        .free_pages (free_pages),
        .released   (released),
        .status     (status)
    );

endmodule

### sim/refcounted_page_allocator_tb.sv
// Self-checking testbench for the reference-counted page allocator.
// A scoreboard class keeps its own free stack and counts, predicts every result and checks it.
// Depends on rcpa_pkg and refcounted_page_allocator.
module refcounted_page_allocator_tb;

    localparam int NUM_PAGES   = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // One result item as seen on the result ports.
    typedef struct {
        logic [11:0] page_index;
        logic [7:0]  ref_count;
        logic [12:0] free_pages;
        logic        released;
        logic [2:0]  status;
    } page_result_t;

    // Page book: shadow allocator state plus the queue of results still owed.
    class page_book;
        logic [11:0]  stack_mem [NUM_PAGES];
        logic [7:0]   counts [NUM_PAGES];
        logic [12:0]  stack_top;
        logic [12:0]  managed;
        page_result_t awaited [$];
        int           checked;
        int           mismatches;

        function new();
            set_pages(13'd4096);
        endfunction

        // A write of the page count clamps it and rebuilds stack and counts.
        function void set_pages(logic [12:0] value);
            if (value == 0)
                managed = 13'd1;
            else if (value > NUM_PAGES)
                managed = 13'(NUM_PAGES);
            else
                managed = value;
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                stack_mem[i] = 12'(i);
                counts[i]    = 8'd0;
            end
            stack_top = managed;
        endfunction

        // Works out the result of one accepted item and updates the shadow state.
        function void predict_item(rcpa_pkg::op_t op, logic [11:0] pg);
            page_result_t r;
            logic [11:0]  top_page;
            r.page_index = pg;
            r.ref_count  = 8'd0;
            r.released   = 1'b0;
            r.status     = rcpa_pkg::ST_OK;
            if (op == rcpa_pkg::OP_ALLOC)
            begin
                r.page_index = 12'd0;
                if (stack_top == 0)
                    r.status = rcpa_pkg::ST_EMPTY;
                else
                begin
                    top_page     = stack_mem[stack_top - 1];
                    r.page_index = top_page;
                    if (counts[top_page] != 0)
                    begin
                        r.status    = rcpa_pkg::ST_POPPED_USED;
                        r.ref_count = counts[top_page];
                    end
                    else
                    begin
                        stack_top        = stack_top - 1;
                        counts[top_page] = 8'd1;
                        r.ref_count      = 8'd1;
                    end
                end
            end
            else if ({1'b0, pg} >= managed)
                r.status = rcpa_pkg::ST_RANGE;
            else
            begin
                r.ref_count = counts[pg];
                case (op)
                    rcpa_pkg::OP_RELEASE:
                    begin
                        if (r.ref_count == 0)
                            r.status = rcpa_pkg::ST_REL_UNUSED;
                        else
                        begin
                            r.ref_count = r.ref_count - 8'd1;
                            counts[pg]  = r.ref_count;
                            // The last reference gone returns the page to the stack.
                            if (r.ref_count == 0 && stack_top < NUM_PAGES)
                            begin
                                stack_mem[stack_top] = pg;
                                stack_top            = stack_top + 1;
                                r.released           = 1'b1;
                            end
                        end
                    end
                    rcpa_pkg::OP_ADDREF:
                    begin
                        if (r.ref_count == 0)
                            r.status = rcpa_pkg::ST_ADD_UNUSED;
                        else if (r.ref_count == 8'd255)
                            r.status = rcpa_pkg::ST_RANGE;
                        else
                        begin
                            r.ref_count = r.ref_count + 8'd1;
                            counts[pg]  = r.ref_count;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.free_pages = stack_top;
            awaited.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH: %s", msg);
        endfunction

        function string show(page_result_t r);
            return $sformatf("page %0d count %0d free %0d released %0b status %0d",
                             r.page_index, r.ref_count, r.free_pages, r.released, r.status);
        endfunction

        // Compares one result item with the oldest prediction.
        function void check_result(page_result_t got);
            page_result_t want;
            if (awaited.size() == 0)
            begin
                note_mismatch({"result with no item outstanding: ", show(got)});
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.page_index !== want.page_index || got.ref_count !== want.ref_count ||
                got.free_pages !== want.free_pages || got.released !== want.released ||
                got.status !== want.status)
                note_mismatch($sformatf("result %0d expected %s, got %s",
                                        checked, show(want), show(got)));
        endfunction

        // Mostly a page that is in use, sometimes any page in range or any page at all.
        function logic [11:0] pick_page();
            int roll;
            int base;
            int idx;
            roll = $urandom_range(0, 99);
            base = $urandom_range(0, managed - 1);
            if (roll < 15)
                return 12'($urandom_range(0, NUM_PAGES - 1));
            if (roll < 75)
            begin
                for (int k = 0; k < managed; k++)
                begin
                    idx = (base + k) % managed;
                    if (counts[idx] != 0)
                        return 12'(idx);
                end
            end
            return 12'(base);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  operation = rcpa_pkg::OP_QUERY;
    logic [11:0] page      = 12'd0;
    logic        cfg_we    = 1'b0;
    logic [12:0] cfg_wdata = 13'd0;
    logic        busy;
    logic        done;
    logic [11:0] page_index;
    logic [7:0]  ref_count;
    logic [12:0] free_pages;
    logic        released;
    logic [2:0]  status;

    page_book book;
    bit       quiet;
    int       items_sent;
    int       settings_used;
    int       cycles;

    refcounted_page_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .page       (page),
        .done       (done),
        .page_index (page_index),
        .ref_count  (ref_count),
        .free_pages (free_pages),
        .released   (released),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Cycle guard against a hung block.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped by the cycle guard after %0d cycles.", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every result item is taken in the cycle that done marks.
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_result('{page_index, ref_count, free_pages, released, status});
    end

    // Presents one item after a random gap and holds it until the block takes it.
    task automatic send_item(rcpa_pkg::op_t op, logic [11:0] pg);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        page      <= pg;
        do
            @(posedge clk);
        while (busy);
        book.predict_item(op, pg);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic settle();
        start <= 1'b0;
        while (book.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the page count while the block is idle.
    task automatic write_pages(logic [12:0] value);
        settle();
        while (busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.set_pages(value);
        settings_used++;
    endtask

    initial
    begin
        logic [12:0]   round_sizes [6];
        rcpa_pkg::op_t op;
        int            roll;
        book = new();
        round_sizes = '{13'd2, 13'd5, 13'd13, 13'd40, 13'd0, 13'd4097};
        round_sizes[4] = 13'($urandom_range(1, 300));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks at the full page count.
        send_item(rcpa_pkg::OP_QUERY, 12'd0);
        send_item(rcpa_pkg::OP_QUERY, 12'd4095);
        send_item(rcpa_pkg::OP_RELEASE, 12'd5);
        send_item(rcpa_pkg::OP_ADDREF, 12'd5);
        send_item(rcpa_pkg::OP_ALLOC, 12'hFFF);
        send_item(rcpa_pkg::OP_ALLOC, 12'd0);
        send_item(rcpa_pkg::OP_ADDREF, 12'd4095);
        send_item(rcpa_pkg::OP_QUERY, 12'd4095);
        send_item(rcpa_pkg::OP_RELEASE, 12'd4095);
        send_item(rcpa_pkg::OP_RELEASE, 12'd4095);
        send_item(rcpa_pkg::OP_ALLOC, 12'd1234);
        send_item(rcpa_pkg::OP_RELEASE, 12'd4094);

        // A zero page count is taken as a single page.
        write_pages(13'd0);
        send_item(rcpa_pkg::OP_QUERY, 12'd1);
        send_item(rcpa_pkg::OP_ADDREF, 12'd4095);
        send_item(rcpa_pkg::OP_RELEASE, 12'd2048);
        send_item(rcpa_pkg::OP_ALLOC, 12'd0);
        send_item(rcpa_pkg::OP_ALLOC, 12'd0);
        send_item(rcpa_pkg::OP_RELEASE, 12'd0);

        // Drive one page's count to its ceiling and past it.
        send_item(rcpa_pkg::OP_ALLOC, 12'd0);
        repeat (254) send_item(rcpa_pkg::OP_ADDREF, 12'd0);
        send_item(rcpa_pkg::OP_ADDREF, 12'd0);
        send_item(rcpa_pkg::OP_QUERY, 12'd0);

        // An oversized page count is clamped to the maximum.
        write_pages(13'h1FFF);
        send_item(rcpa_pkg::OP_QUERY, 12'd4095);

        // Random rounds, mostly on small page counts so the stack runs dry.
        for (int r = 0; r < 6; r++)
        begin
            write_pages(round_sizes[r]);
            for (int n = 0; n < 40; n++)
            begin
                if (n % 20 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if (n == 20)
                    settle();
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    op = rcpa_pkg::OP_ALLOC;
                else if (roll < 65)
                    op = rcpa_pkg::OP_RELEASE;
                else if (roll < 85)
                    op = rcpa_pkg::OP_ADDREF;
                else
                    op = rcpa_pkg::OP_QUERY;
                send_item(op, (op == rcpa_pkg::OP_ALLOC) ? 12'($urandom) : book.pick_page());
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (book.awaited.size() != 0)
            book.note_mismatch($sformatf("%0d results never arrived", book.awaited.size()));
        $display("Sent %0d items across %0d page-count settings; checked %0d results.",
                 items_sent, settings_used + 1, book.checked);
        $display("Mismatches found: %0d.", book.mismatches);
        if (book.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### refcounted_page_allocator.f
hw/rtl/rcpa_pkg.sv
hw/rtl/rcpa_ctrl.sv
hw/rtl/rcpa_datapath.sv
hw/rtl/refcounted_page_allocator.sv
sim/refcounted_page_allocator_tb.sv
